/* sv/sspq_pkg.sv */
// types and constants for the stable sorted priority queue
// used by sspq_cell and stable_sorted_priority_queue_top; no dependencies

package sspq_pkg;

	localparam logic       KIND_ENQ = 1'b0;
	localparam logic       KIND_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic signed [31:0] EMPTY_MARK = -32'sd999;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] item_value;
		logic signed [31:0] item_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] taken_value;
		logic signed [31:0] head_value;
		logic               is_empty;
		logic [4:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	typedef struct packed {
		logic               enq;
		logic               deq;
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} cell_cmd_t;

endpackage

/* sv/sspq_cell.sv */
// one slot of the sorted queue chain: holds an entry, compares against the new priority
// and shifts with its neighbors; depends on sspq_pkg

module sspq_cell #(
	parameter int IDX   = 0,
	parameter int OCC_W = 5
) (
	input  logic               clk,
	input  sspq_pkg::cell_cmd_t cmd,
	input  logic [OCC_W-1:0]   occ,
	input  logic               prev_ins,
	input  sspq_pkg::entry_t   left,
	input  sspq_pkg::entry_t   right,
	output logic               ins,
	output sspq_pkg::entry_t   entry
);
	import sspq_pkg::*;

	entry_t entry_q;
	logic   live;

	// new pair goes in front of this slot when the slot is empty or strictly lower
	assign live  = (OCC_W'(IDX) < occ);
	assign ins   = !live || (cmd.prio > entry_q.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.enq && ins) begin
			if (prev_ins) begin
				entry_q <= left;
			end else begin
				entry_q.value <= cmd.value;
				entry_q.prio  <= cmd.prio;
			end
		end else if (cmd.deq) begin
			entry_q <= right;
		end
	end

endmodule

/* sv/stable_sorted_priority_queue_top.sv */
// stable sorted priority queue: a chain of DEPTH cells kept in descending priority order
// result: registered, valid in the cycle after the request transfer
// throughput: one request per cycle (cell compare and shift) unless an unread result stalls
// reset: arst_n clears the count and the result valid; slot contents stay undefined
// depends on sspq_pkg and sspq_cell

module stable_sorted_priority_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  sspq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output sspq_pkg::rsp_t  rsp
);
	import sspq_pkg::*;

	localparam int OCC_W = $clog2(DEPTH + 1);

	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] occ_next;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;

	logic             accept;
	logic             is_full;
	logic             enq_ok;
	logic             deq_ok;
	cell_cmd_t        cmd;

	logic   [DEPTH-1:0] ins;
	entry_t             ent   [DEPTH];
	entry_t             left  [DEPTH];
	entry_t             right [DEPTH];
	logic   [DEPTH-1:0] prev_ins;

	assign accept    = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign is_full   = (occ_q == OCC_W'(DEPTH));
	assign enq_ok    = accept && (req.kind == KIND_ENQ) && !is_full;
	assign deq_ok    = accept && (req.kind == KIND_DEQ) && (occ_q != '0);

	assign cmd.enq   = enq_ok;
	assign cmd.deq   = deq_ok;
	assign cmd.value = req.item_value;
	assign cmd.prio  = req.item_priority;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_ins[i] = 1'b0;
			assign left[i]     = '0;
		end else begin : g_mid
			assign prev_ins[i] = ins[i-1];
			assign left[i]     = ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right[i] = '0;
		end else begin : g_inner
			assign right[i] = ent[i+1];
		end

		sspq_cell #(
			.IDX   (i),
			.OCC_W (OCC_W)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occ      (occ_q),
			.prev_ins (prev_ins[i]),
			.left     (left[i]),
			.right    (right[i]),
			.ins      (ins[i]),
			.entry    (ent[i])
		);
	end

	always_comb begin
		occ_next = occ_q;
		if (enq_ok) begin
			occ_next = occ_q + OCC_W'(1);
		end else if (deq_ok) begin
			occ_next = occ_q - OCC_W'(1);
		end

		rsp_next.status      = ST_OK;
		rsp_next.taken_value = '0;
		if (req.kind == KIND_DEQ) begin
			if (deq_ok) begin
				rsp_next.taken_value = ent[0].value;
			end else begin
				rsp_next.status      = ST_EMPTY;
				rsp_next.taken_value = EMPTY_MARK;
			end
		end else if (is_full) begin
			rsp_next.status = ST_FULL;
		end

		if (enq_ok) begin
			rsp_next.head_value = ins[0] ? req.item_value : ent[0].value;
		end else if (deq_ok) begin
			rsp_next.head_value = (occ_q > OCC_W'(1)) ? ent[1].value : EMPTY_MARK;
		end else begin
			rsp_next.head_value = (occ_q == '0) ? EMPTY_MARK : ent[0].value;
		end

		rsp_next.is_empty    = (occ_next == '0);
		rsp_next.entry_count = 5'(occ_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above depth");

	a_occ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(occ_q))
		else $error("occupancy changed without a transfer");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.kind == KIND_ENQ) && is_full |=> rsp_q.status == ST_FULL && $stable(occ_q))
		else $error("enqueue on full queue not dropped");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.is_empty == (occ_q == '0)))
		else $error("empty flag disagrees with occupancy");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for stable_sorted_priority_queue_top: directed rows, then random traffic
// keeps its own sorted copy of the queue to predict every result; depends on sspq_pkg
`timescale 1ns / 1ps

module tb_top;
	import sspq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam logic signed [31:0] MINV = 32'sh80000000;

	typedef struct packed {
		logic on;
		rsp_t v;
	} typed_rsp_t;

	typedef struct {
		req_t r;
		logic typed;
		rsp_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic       cur_typed;
	rsp_t       cur_want;
	logic       req_fire;
	logic [7:0] stall_phase;

	logic signed [31:0] sorted_val [DEPTH];
	logic signed [31:0] sorted_pri [DEPTH];
	int                 held;
	int                 peak_held;

	rsp_t       pending_rsp [$];
	typed_rsp_t typed_rsp [$];
	row_t       directed_rows [$];

	int errors;
	int idle_cycles;
	int n_enq_ok;
	int n_deq_ok;
	int n_full_drop;
	int n_empty_deq;

	stable_sorted_priority_queue_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_fields(input rsp_t got, input rsp_t want, input string src);
		if (got.status !== want.status)
			report_error($sformatf("%s status got %0d want %0d", src, got.status, want.status));
		if (got.taken_value !== want.taken_value)
			report_error($sformatf("%s taken_value got %0d want %0d", src,
				got.taken_value, want.taken_value));
		if (got.head_value !== want.head_value)
			report_error($sformatf("%s head_value got %0d want %0d", src,
				got.head_value, want.head_value));
		if (got.is_empty !== want.is_empty)
			report_error($sformatf("%s is_empty got %0d want %0d", src,
				got.is_empty, want.is_empty));
		if (got.entry_count !== want.entry_count)
			report_error($sformatf("%s entry_count got %0d want %0d", src,
				got.entry_count, want.entry_count));
	endtask

	function automatic rsp_t queue_step(input req_t r);
		rsp_t               e;
		int                 pos;
		logic signed [31:0] p;
		p = r.item_priority;
		e = '0;
		e.status = ST_OK;
		if (r.kind == KIND_ENQ) begin
			if (held >= DEPTH) begin
				e.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held && p <= sorted_pri[pos])
					pos++;
				for (int i = held; i > pos; i--) begin
					sorted_val[i] = sorted_val[i-1];
					sorted_pri[i] = sorted_pri[i-1];
				end
				sorted_val[pos] = r.item_value;
				sorted_pri[pos] = p;
				held++;
			end
		end else begin
			if (held == 0) begin
				e.status      = ST_EMPTY;
				e.taken_value = EMPTY_MARK;
			end else begin
				e.taken_value = sorted_val[0];
				for (int i = 1; i < held; i++) begin
					sorted_val[i-1] = sorted_val[i];
					sorted_pri[i-1] = sorted_pri[i];
				end
				held--;
			end
		end
		e.head_value  = (held == 0) ? EMPTY_MARK : sorted_val[0];
		e.is_empty    = (held == 0);
		e.entry_count = held[4:0];
		return e;
	endfunction

	// scoreboard: results are compared before this edge's request is predicted
	always @(posedge clk or negedge arst_n) begin
		rsp_t       want;
		typed_rsp_t tw;
		if (!arst_n) begin
			req_fire    <= 1'b0;
			held        = 0;
			idle_cycles = 0;
		end else begin
			req_fire <= req_valid && req_ready;
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					report_error("result transfer with nothing expected");
				end else begin
					want = pending_rsp.pop_front();
					tw   = typed_rsp.pop_front();
					check_fields(rsp, want, "predicted");
					if (tw.on)
						check_fields(rsp, tw.v, "directed");
				end
			end
			if (req_valid && req_ready) begin
				want = queue_step(req);
				pending_rsp.push_back(want);
				typed_rsp.push_back({cur_typed, cur_want});
				case (want.status)
					ST_FULL:  n_full_drop++;
					ST_EMPTY: n_empty_deq++;
					default: begin
						if (req.kind == KIND_ENQ)
							n_enq_ok++;
						else
							n_deq_ok++;
					end
				endcase
				if (held > peak_held)
					peak_held = held;
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// receiver stall pattern: open, coin flip, mostly stalled, alternating
	always @(negedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		case (stall_phase[7:6])
			2'd0: rsp_ready <= 1'b1;
			2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
			2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ready <= stall_phase[1];
		endcase
	end

	task automatic push_req(input req_t r);
		req       = r;
		req_valid = 1'b1;
		do @(negedge clk); while (!req_fire);
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			req_valid = 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	task automatic add_row(input logic kind, input logic signed [31:0] val,
			input logic signed [31:0] pri, input logic typed, input logic [1:0] st,
			input logic signed [31:0] taken, input logic signed [31:0] head,
			input logic emp, input int cnt);
		row_t row;
		row.r.kind           = kind;
		row.r.item_value     = val;
		row.r.item_priority  = pri;
		row.typed            = typed;
		row.want.status      = st;
		row.want.taken_value = taken;
		row.want.head_value  = head;
		row.want.is_empty    = emp;
		row.want.entry_count = cnt[4:0];
		directed_rows.push_back(row);
	endtask

	function automatic logic signed [31:0] pick_priority(input int pmode);
		logic signed [31:0] p;
		case (pmode)
			0: p = $urandom;
			1: p = $signed($urandom_range(0, 3)) - 2;
			2: begin
				case ($urandom_range(0, 3))
					0: p = MAXV;
					1: p = MINV;
					2: p = 0;
					default: p = -1;
				endcase
			end
			default: p = $signed($urandom_range(0, 16)) - 8;
		endcase
		return p;
	endfunction

	initial begin
		req_t r;
		int   n;
		int   burst;
		int   bias;
		int   pmode;
		int   since_bias;

		clk         = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b0;
		stall_phase = '0;
		cur_typed   = 1'b0;
		cur_want    = '0;
		errors      = 0;
		peak_held   = 0;
		n_enq_ok    = 0;
		n_deq_ok    = 0;
		n_full_drop = 0;
		n_empty_deq = 0;

		add_row(KIND_DEQ, MAXV, MINV, 1, ST_EMPTY, EMPTY_MARK, EMPTY_MARK, 1, 0);
		add_row(KIND_ENQ, MAXV, MINV, 1, ST_OK, 0, MAXV, 0, 1);
		add_row(KIND_ENQ, MINV, MAXV, 1, ST_OK, 0, MINV, 0, 2);
		add_row(KIND_ENQ, 0, MAXV, 1, ST_OK, 0, MINV, 0, 3);
		add_row(KIND_DEQ, -1, -1, 1, ST_OK, MINV, 0, 0, 2);
		add_row(KIND_DEQ, 0, 0, 1, ST_OK, 0, MAXV, 0, 1);
		add_row(KIND_DEQ, MINV, MAXV, 1, ST_OK, MAXV, EMPTY_MARK, 1, 0);
		for (int i = 0; i < DEPTH; i++)
			add_row(KIND_ENQ, 100 + i, i % 4, 0, ST_OK, 0, 0, 0, 0);
		add_row(KIND_ENQ, 999, MAXV, 1, ST_FULL, 0, 103, 0, DEPTH);
		add_row(KIND_DEQ, 0, 0, 1, ST_OK, 103, 107, 0, DEPTH - 1);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			cur_typed = directed_rows[i].typed;
			cur_want  = directed_rows[i].want;
			push_req(directed_rows[i].r);
			idle_gap($urandom_range(0, 2));
		end
		cur_typed = 1'b0;

		n          = 0;
		bias       = 50;
		pmode      = 0;
		since_bias = 0;
		while (n < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			if ($urandom_range(0, 7) == 0)
				burst = $urandom_range(30, 80);
			for (int b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
				if (since_bias == 0) begin
					case ($urandom_range(0, 3))
						0: bias = 15;
						1: bias = 50;
						2: bias = 85;
						default: bias = 100;
					endcase
					pmode      = $urandom_range(0, 3);
					since_bias = $urandom_range(20, 60);
				end
				since_bias--;
				r.kind          = ($urandom_range(0, 99) < bias) ? KIND_ENQ : KIND_DEQ;
				r.item_value    = ($urandom_range(0, 15) == 0) ? EMPTY_MARK : $urandom;
				r.item_priority = pick_priority(pmode);
				push_req(r);
				n++;
			end
			idle_gap($urandom_range(0, 5));
		end
		req_valid = 1'b0;

		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d enqueues, %0d dequeues, %0d drops on full, %0d dequeues on empty",
			n_enq_ok, n_deq_ok, n_full_drop, n_empty_deq);
		$display("peak occupancy %0d of %0d, %0d mismatches", peak_held, DEPTH, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, pending_rsp.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
sv/sspq_pkg.sv
sv/sspq_cell.sv
sv/stable_sorted_priority_queue_top.sv
tb/tb_top.sv
